@@ design/intra_block_predictor_assert.svh @@
// Assertion macros shared by the checker of the intra block predictor.
`ifndef INTRA_BLOCK_PREDICTOR_ASSERT_SVH
`define INTRA_BLOCK_PREDICTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset as well.
`define IBP_ASSERT_NXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ibp_pkg.sv @@
// Shared types, constants and pixel functions of the intra block predictor.
package ibp_pkg;

  localparam int MAX_BLOCK       = 32;
  localparam int PIXELS_PER_WORD = 8;
  localparam int PIX_W           = 8;
  localparam int WORD_W          = PIXELS_PER_WORD * PIX_W;
  localparam int WORDS_MAX       = MAX_BLOCK / PIXELS_PER_WORD;
  localparam int WIDX_W          = 2;
  localparam int POS_W           = 5;
  localparam int SUM_W           = 13;
  localparam int CMDQ_DEPTH      = 4;
  localparam int OUTQ_DEPTH      = 4;

  // Item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_GEN  = 1'b1;

  // Predictor codes; anything unlisted behaves as constant 128
  localparam logic [2:0] KIND_DC      = 3'd0;
  localparam logic [2:0] KIND_DC_LEFT = 3'd1;
  localparam logic [2:0] KIND_DC_TOP  = 3'd2;
  localparam logic [2:0] KIND_DC_128  = 3'd3;
  localparam logic [2:0] KIND_HOR     = 3'd4;
  localparam logic [2:0] KIND_VER     = 3'd5;
  localparam logic [2:0] KIND_TM      = 3'd6;

  localparam logic [PIX_W-1:0] DC_MID = 8'd128;

  // Classified command passed from front to back
  typedef struct packed {
    logic              is_gen;
    logic [POS_W-1:0]  pos;
    logic [PIX_W-1:0]  above;
    logic [PIX_W-1:0]  left;
    logic [2:0]        kind;
    logic              big;
    logic [PIX_W-1:0]  dc;
    logic [PIX_W-1:0]  corner;
  } cmd_t;

  // One result word
  typedef struct packed {
    logic [WORD_W-1:0] pixels;
    logic [WIDX_W-1:0] word_index;
    logic              last;
  } res_t;

  // Clamp a 10-bit value to 0..255
  function automatic logic [PIX_W-1:0] sat8(input logic [9:0] v);
    sat8 = (v > 10'd255) ? 8'd255 : v[7:0];
  endfunction

  // True motion: left + above - corner, clamped to 0..255
  function automatic logic [PIX_W-1:0] tm_pixel(input logic [PIX_W-1:0] l,
                                                 input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] c);
    logic signed [9:0] s;
    s = $signed({2'b00, l}) + $signed({2'b00, a}) - $signed({2'b00, c});
    if (s < 0) begin
      tm_pixel = 8'd0;
    end else if (s > 10'sd255) begin
      tm_pixel = 8'd255;
    end else begin
      tm_pixel = s[7:0];
    end
  endfunction

endpackage

@@ design/ibp_front.sv @@
// Front end: accepts items, keeps edge sums and corner, classifies into commands.
module ibp_front
  import ibp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_mode,
  input  logic [POS_W-1:0] in_position,
  input  logic [PIX_W-1:0] in_above_pixel,
  input  logic [PIX_W-1:0] in_left_pixel,
  input  logic [PIX_W-1:0] in_corner_pixel,
  input  logic [2:0]       in_pred_kind,
  input  logic             in_size_is_32,
  output logic             q_push,
  output cmd_t             q_cmd,
  input  logic             q_full
);

  logic [SUM_W-1:0] above_sum_r, above_sum_nxt;
  logic [SUM_W-1:0] left_sum_r, left_sum_nxt;
  logic [PIX_W-1:0] corner_r;
  logic             accept;
  logic             is_load;
  logic [14:0]      both_sum;
  logic [13:0]      left_rnd;
  logic [13:0]      top_rnd;
  logic [9:0]       dc_both;
  logic [9:0]       dc_left;
  logic [9:0]       dc_top;
  logic [PIX_W-1:0] dc;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;
  assign is_load = (in_mode == MODE_LOAD);

  // Restart sums on index zero, else accumulate with wrap
  always_comb begin
    if (in_position == '0) begin
      above_sum_nxt = SUM_W'(in_above_pixel);
      left_sum_nxt  = SUM_W'(in_left_pixel);
    end else begin
      above_sum_nxt = above_sum_r + SUM_W'(in_above_pixel);
      left_sum_nxt  = left_sum_r + SUM_W'(in_left_pixel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_sum_r <= '0;
      left_sum_r  <= '0;
      corner_r    <= '0;
    end else if (accept && is_load) begin
      above_sum_r <= above_sum_nxt;
      left_sum_r  <= left_sum_nxt;
      corner_r    <= in_corner_pixel;
    end
  end

  // DC averages with rounding, then saturate
  assign both_sum = 15'(above_sum_r) + 15'(left_sum_r) + (in_size_is_32 ? 15'd32 : 15'd16);
  assign left_rnd = 14'(left_sum_r) + (in_size_is_32 ? 14'd16 : 14'd8);
  assign top_rnd  = 14'(above_sum_r) + (in_size_is_32 ? 14'd16 : 14'd8);
  assign dc_both  = in_size_is_32 ? 10'(both_sum >> 6) : 10'(both_sum >> 5);
  assign dc_left  = in_size_is_32 ? 10'(left_rnd >> 5) : 10'(left_rnd >> 4);
  assign dc_top   = in_size_is_32 ? 10'(top_rnd >> 5) : 10'(top_rnd >> 4);

  always_comb begin
    unique case (in_pred_kind)
      KIND_DC:      dc = sat8(dc_both);
      KIND_DC_LEFT: dc = sat8(dc_left);
      KIND_DC_TOP:  dc = sat8(dc_top);
      default:      dc = DC_MID;
    endcase
  end

  // Pack command; generates snapshot DC and corner at acceptance
  always_comb begin
    q_cmd.is_gen = (in_mode == MODE_GEN);
    q_cmd.pos    = in_position;
    q_cmd.above  = in_above_pixel;
    q_cmd.left   = in_left_pixel;
    q_cmd.kind   = in_pred_kind;
    q_cmd.big    = in_size_is_32;
    q_cmd.dc     = dc;
    q_cmd.corner = corner_r;
  end

  assign q_push = accept;

endmodule

@@ design/ibp_cmdq.sv @@
// Command queue between the front end and the back end.
module ibp_cmdq
  import ibp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W:0]     count_r;
  logic               do_push;
  logic               do_pop;

  assign full    = (count_r == (PTR_W+1)'(CMDQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

endmodule

@@ design/ibp_back.sv @@
// Back end: edge memories, row word sequencer, pixel lanes and result queue.
module ibp_back
  import ibp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [WORD_W-1:0] out_pixels,
  output logic [WIDX_W-1:0] out_word_index,
  output logic              out_last
);

  localparam int OQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int LANE_W   = $clog2(PIXELS_PER_WORD);

  // Edge memories: above row word-organized, left column by pixel
  logic [PIX_W-1:0]    above_mem_r [WORDS_MAX][PIXELS_PER_WORD];
  logic [PIX_W-1:0]    left_mem_r  [MAX_BLOCK];

  // Sequencer
  logic                busy_r;
  logic [WIDX_W-1:0]   word_r;
  cmd_t                gen_r;
  logic [POS_W-1:0]    row_r;
  logic                issue;
  logic                issue_last;
  logic                room;
  logic [WIDX_W-1:0]   words_last;

  // Read stage
  logic                s1_valid_r;
  logic [WIDX_W-1:0]   s1_word_r;
  logic                s1_last_r;
  logic [2:0]          s1_kind_r;
  logic [PIX_W-1:0]    s1_dc_r;
  logic [PIX_W-1:0]    s1_corner_r;
  logic [PIX_W-1:0]    above_q_r [PIXELS_PER_WORD];
  logic [PIX_W-1:0]    left_q_r;
  logic [WORD_W-1:0]   lane_pixels;

  // Result queue
  res_t                oq_mem_r [OUTQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_r;
  logic [OQ_PTR_W-1:0] oq_rd_r;
  logic [OQ_PTR_W:0]   oq_cnt_r;
  logic                oq_pop;
  res_t                oq_head;

  // Issue a word read only when the result queue can take it
  assign room       = ({1'b0, oq_cnt_r} + (OQ_PTR_W+2)'(s1_valid_r)) <
                      (OQ_PTR_W+2)'(OUTQ_DEPTH);
  assign words_last = gen_r.big ? WIDX_W'(WORDS_MAX - 1) : WIDX_W'(WORDS_MAX/2 - 1);
  assign issue      = busy_r && room;
  assign issue_last = issue && (word_r == words_last);
  assign q_pop      = !q_empty && (!busy_r || issue_last);

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      word_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
      priority if (q_pop && q_cmd.is_gen) begin
        busy_r <= 1'b1;
        word_r <= '0;
      end else if (issue_last) begin
        busy_r <= 1'b0;
      end else if (issue) begin
        word_r <= word_r + 1'b1;
      end
    end
  end

  // Latch generate command and read-stage payload
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.is_gen) begin
      gen_r <= q_cmd;
      row_r <= q_cmd.big ? q_cmd.pos : {1'b0, q_cmd.pos[POS_W-2:0]};
    end
    if (issue) begin
      s1_word_r   <= word_r;
      s1_last_r   <= issue_last;
      s1_kind_r   <= gen_r.kind;
      s1_dc_r     <= gen_r.dc;
      s1_corner_r <= gen_r.corner;
    end
  end

  // Write edges on loads, read one word and one left pixel per issue
  always_ff @(posedge clk) begin
    if (q_pop && !q_cmd.is_gen) begin
      above_mem_r[q_cmd.pos[POS_W-1:LANE_W]][q_cmd.pos[LANE_W-1:0]] <= q_cmd.above;
      left_mem_r[q_cmd.pos] <= q_cmd.left;
    end
    if (issue) begin
      above_q_r <= above_mem_r[word_r];
      left_q_r  <= left_mem_r[row_r];
    end
  end

  // Form the eight pixels of a word
  always_comb begin
    for (int k = 0; k < PIXELS_PER_WORD; k++) begin
      unique case (s1_kind_r)
        KIND_HOR: lane_pixels[k*PIX_W +: PIX_W] = left_q_r;
        KIND_VER: lane_pixels[k*PIX_W +: PIX_W] = above_q_r[k];
        KIND_TM:  lane_pixels[k*PIX_W +: PIX_W] = tm_pixel(left_q_r, above_q_r[k],
                                                           s1_corner_r);
        default:  lane_pixels[k*PIX_W +: PIX_W] = s1_dc_r;
      endcase
    end
  end

  // Result queue control
  assign oq_pop    = out_pop && (oq_cnt_r != '0);
  assign out_empty = (oq_cnt_r == '0);
  assign oq_head   = oq_mem_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (s1_valid_r) oq_wr_r <= oq_wr_r + 1'b1;
      if (oq_pop)     oq_rd_r <= oq_rd_r + 1'b1;
      if (s1_valid_r && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (oq_pop && !s1_valid_r) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      oq_mem_r[oq_wr_r] <= '{pixels: lane_pixels, word_index: s1_word_r,
                             last: s1_last_r};
    end
  end

  assign out_pixels     = oq_head.pixels;
  assign out_word_index = oq_head.word_index;
  assign out_last       = oq_head.last;

endmodule

@@ design/intra_block_predictor.sv @@
// Top level of the intra block predictor: front end, command queue, back end.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------------
//   in_      | in_push / in_full   | mode, position, above/left/corner, kind, size
//   out_     | out_pop / out_empty | pixels, word_index, last
//
// A load writes the edge memories when the back end pops it; a generate emits 2
// (size 16) or 4 (size 32) words, one per cycle while the result queue has room,
// paced by one word read of the above-edge memory per cycle.
// Synchronous active-low reset clears sums, corner, queues and sequencer; edge
// memories have no reset and no clearing pass.
// The front stalls only when the four-entry command queue is full; the back stalls
// when the four-entry result queue has no room.
module intra_block_predictor
  import ibp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_mode,
  input  logic [POS_W-1:0]  in_position,
  input  logic [PIX_W-1:0]  in_above_pixel,
  input  logic [PIX_W-1:0]  in_left_pixel,
  input  logic [PIX_W-1:0]  in_corner_pixel,
  input  logic [2:0]        in_pred_kind,
  input  logic              in_size_is_32,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [WORD_W-1:0] out_pixels,
  output logic [WIDX_W-1:0] out_word_index,
  output logic              out_last
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_cmd_in;
  cmd_t q_cmd_out;

  ibp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_mode         (in_mode),
    .in_position     (in_position),
    .in_above_pixel  (in_above_pixel),
    .in_left_pixel   (in_left_pixel),
    .in_corner_pixel (in_corner_pixel),
    .in_pred_kind    (in_pred_kind),
    .in_size_is_32   (in_size_is_32),
    .q_push          (q_push),
    .q_cmd           (q_cmd_in),
    .q_full          (q_full)
  );

  ibp_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_cmd_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_cmd_out),
    .empty (q_empty)
  );

  ibp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (q_cmd_out),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_pixels     (out_pixels),
    .out_word_index (out_word_index),
    .out_last       (out_last)
  );

endmodule

@@ design/ibp_checker.sv @@
// Port-level checker for the intra block predictor, bound to the top level.
`include "intra_block_predictor_assert.svh"

module ibp_checker
  import ibp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input logic [WORD_W-1:0] out_pixels,
  input logic [WIDX_W-1:0] out_word_index,
  input logic              out_last
);

  // Reset leaves both queues empty
  `IBP_ASSERT_NXT_ALWAYS(a_reset_idle, !rst_n, out_empty && !in_full, "queues not empty after reset")

  // A row ends on word 1 or word 3
  `IBP_ASSERT_IMP(a_last_index, !out_empty && out_last, out_word_index == 2'd1 || out_word_index == 2'd3, "last on wrong word")

  // Words of a row come out in order
  `IBP_ASSERT_NXT(a_word_order, !out_empty && out_pop && !out_last, out_empty || out_word_index == $past(out_word_index) + 2'd1, "word out of order")

  // A new row starts at word 0
  `IBP_ASSERT_NXT(a_row_start, !out_empty && out_pop && out_last, out_empty || out_word_index == 2'd0, "row does not start at word 0")

  // A waiting transaction holds
  `IBP_ASSERT_NXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_pixels) && $stable(out_last), "waiting result changed")

endmodule

bind intra_block_predictor ibp_checker u_ibp_checker (.*);

@@ tb/sv/tb.sv @@
// Self-checking testbench for the intra block predictor: edge loads and predicted-row checks.
module tb
  import ibp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Code 7 has no name in the package; the block treats it as constant 128
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_CYCLES = 20;

  // Predicts every word of a row and checks the words that come out
  class row_scoreboard;
    logic [PIX_W-1:0] above_edge [MAX_BLOCK];
    logic [PIX_W-1:0] left_edge [MAX_BLOCK];
    logic [PIX_W-1:0] corner;
    logic [SUM_W-1:0] above_total;
    logic [SUM_W-1:0] left_total;
    res_t             expected_words[$];
    int               n_fail;

    function new();
      foreach (above_edge[i]) begin
        above_edge[i] = '0;
        left_edge[i]  = '0;
      end
      corner      = '0;
      above_total = '0;
      left_total  = '0;
      n_fail      = 0;
    endfunction

    function logic [PIX_W-1:0] clip_pixel(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[PIX_W-1:0];
    endfunction

    // Update the edge state on a load, or queue the words of a predicted row
    function void note_item(logic mode, logic [POS_W-1:0] pos, logic [PIX_W-1:0] ap,
                            logic [PIX_W-1:0] lp, logic [PIX_W-1:0] cp,
                            logic [2:0] kind, logic big);
      int               size;
      int               lg;
      int               row;
      int               col;
      int               words;
      logic [PIX_W-1:0] dc;
      logic [PIX_W-1:0] pix;
      res_t             r;
      if (mode == MODE_LOAD) begin
        above_edge[pos] = ap;
        left_edge[pos]  = lp;
        corner          = cp;
        if (pos == 0) begin
          above_total = SUM_W'(ap);
          left_total  = SUM_W'(lp);
        end else begin
          above_total = above_total + SUM_W'(ap);
          left_total  = left_total + SUM_W'(lp);
        end
        return;
      end
      size  = big ? 32 : 16;
      lg    = big ? 5 : 4;
      row   = pos & (size - 1);
      words = size / PIXELS_PER_WORD;
      case (kind)
        KIND_DC:      dc = clip_pixel((int'(above_total) + int'(left_total) + size) >> (lg + 1));
        KIND_DC_LEFT: dc = clip_pixel((int'(left_total) + size / 2) >> lg);
        KIND_DC_TOP:  dc = clip_pixel((int'(above_total) + size / 2) >> lg);
        default:      dc = DC_MID;
      endcase
      for (int w = 0; w < words; w++) begin
        r = '0;
        for (int k = 0; k < PIXELS_PER_WORD; k++) begin
          col = w * PIXELS_PER_WORD + k;
          case (kind)
            KIND_HOR: pix = left_edge[row];
            KIND_VER: pix = above_edge[col];
            KIND_TM:  pix = clip_pixel(int'(left_edge[row]) + int'(above_edge[col]) -
                                       int'(corner));
            default:  pix = dc;
          endcase
          r.pixels[k*PIX_W +: PIX_W] = pix;
        end
        r.word_index = w[WIDX_W-1:0];
        r.last       = (w == words - 1);
        expected_words.push_back(r);
      end
    endfunction

    // Compare one accepted word with the oldest expected one
    function void check_word(logic [WORD_W-1:0] pixels, logic [WIDX_W-1:0] widx,
                             logic last);
      res_t e;
      if (expected_words.size() == 0) begin
        if (n_fail < 10)
          $display("unexpected word: pixels %h index %0d last %0b", pixels, widx, last);
        n_fail++;
        return;
      end
      e = expected_words.pop_front();
      if (e.pixels !== pixels || e.word_index !== widx || e.last !== last) begin
        if (n_fail < 10)
          $display("word mismatch: expected pixels %h index %0d last %0b, got %h %0d %0b",
                   e.pixels, e.word_index, e.last, pixels, widx, last);
        n_fail++;
      end
    endfunction

    function int pending_count();
      return expected_words.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic              in_mode;
  logic [POS_W-1:0]  in_position;
  logic [PIX_W-1:0]  in_above_pixel;
  logic [PIX_W-1:0]  in_left_pixel;
  logic [PIX_W-1:0]  in_corner_pixel;
  logic [2:0]        in_pred_kind;
  logic              in_size_is_32;
  logic              out_empty;
  logic              out_pop;
  logic [WORD_W-1:0] out_pixels;
  logic [WIDX_W-1:0] out_word_index;
  logic              out_last;

  row_scoreboard sb;
  bit            calm;
  bit            stall_req;
  bit            above_seen [MAX_BLOCK];
  bit            left_seen [MAX_BLOCK];
  int            n_items;

  intra_block_predictor DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_mode        (in_mode),
    .in_position    (in_position),
    .in_above_pixel (in_above_pixel),
    .in_left_pixel  (in_left_pixel),
    .in_corner_pixel(in_corner_pixel),
    .in_pred_kind   (in_pred_kind),
    .in_size_is_32  (in_size_is_32),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_pixels     (out_pixels),
    .out_word_index (out_word_index),
    .out_last       (out_last)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Pixel values biased toward the extremes
  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one transaction and hold it until the block takes it
  task automatic push_item(logic mode, logic [POS_W-1:0] pos, logic [PIX_W-1:0] ap,
                           logic [PIX_W-1:0] lp, logic [PIX_W-1:0] cp,
                           logic [2:0] kind, logic big);
    if (!calm && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_push = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    @(negedge clk);
    in_push         = 1'b1;
    in_mode         = mode;
    in_position     = pos;
    in_above_pixel  = ap;
    in_left_pixel   = lp;
    in_corner_pixel = cp;
    in_pred_kind    = kind;
    in_size_is_32   = big;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_item(mode, pos, ap, lp, cp, kind, big);
    n_items++;
  endtask

  task automatic load_edge(logic [POS_W-1:0] pos, logic [PIX_W-1:0] ap,
                           logic [PIX_W-1:0] lp, logic [PIX_W-1:0] cp);
    push_item(MODE_LOAD, pos, ap, lp, cp, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    above_seen[pos] = 1'b1;
    left_seen[pos]  = 1'b1;
  endtask

  // Request a row; fall back to a DC kind if it would read never-loaded edges
  task automatic gen_row(logic [POS_W-1:0] pos, logic [2:0] kind, logic big);
    logic [2:0] k;
    int         size;
    int         row;
    bit         ready;
    k     = kind;
    size  = big ? 32 : 16;
    row   = pos & (size - 1);
    ready = 1'b1;
    if (k == KIND_HOR || k == KIND_TM) ready &= left_seen[row];
    if (k == KIND_VER || k == KIND_TM)
      for (int c = 0; c < size; c++) ready &= above_seen[c];
    if (!ready) begin
      case ($urandom_range(0, 4))
        0:       k = KIND_DC;
        1:       k = KIND_DC_LEFT;
        2:       k = KIND_DC_TOP;
        3:       k = KIND_DC_128;
        default: k = KIND_UNUSED;
      endcase
    end
    push_item(MODE_GEN, pos, rand_pixel(), rand_pixel(), rand_pixel(), k, big);
  endtask

  // Load the edges of one block (possibly cut short), then request a few rows
  task automatic load_block(logic big, bit broken);
    int size;
    int stop;
    size = big ? 32 : 16;
    stop = broken ? $urandom_range(1, size - 1) : size;
    for (int i = 0; i < stop; i++)
      load_edge(POS_W'(i), rand_pixel(), rand_pixel(), rand_pixel());
    repeat ($urandom_range(2, 5))
      gen_row(POS_W'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
              ($urandom_range(0, 5) == 0) ? ~big : big);
  endtask

  // Pile up loads without a restart so the sums saturate DC and later wrap
  task automatic pile_sums();
    repeat (2) begin
      repeat ($urandom_range(16, 20))
        load_edge(POS_W'($urandom_range(1, 31)), 8'd255, 8'd255, rand_pixel());
      gen_row(POS_W'($urandom_range(0, 31)), KIND_DC, 1'b0);
      gen_row(POS_W'($urandom_range(0, 31)), KIND_DC_LEFT, 1'b0);
      gen_row(POS_W'($urandom_range(0, 31)), KIND_DC_TOP, 1'b1);
    end
  endtask

  // Hold the sender until every expected word has come out
  task automatic drain();
    @(negedge clk);
    in_push = 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  // Result side: random pop bursts, one long hold on request
  initial begin
    int hold;
    hold    = 0;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        hold      = LONG_HOLD;
      end else if (hold == 0 && !calm && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 12);
      end
      if (hold > 0) begin
        out_pop = 1'b0;
        hold--;
      end else begin
        out_pop = 1'b1;
      end
      @(posedge clk);
      if (out_pop && !out_empty) sb.check_word(out_pixels, out_word_index, out_last);
    end
  end

  // Stimulus
  initial begin
    int rand_goal;
    sb              = new();
    calm            = 1'b0;
    stall_req       = 1'b0;
    n_items         = 0;
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_mode         = MODE_LOAD;
    in_position     = '0;
    in_above_pixel  = '0;
    in_left_pixel   = '0;
    in_corner_pixel = '0;
    in_pred_kind    = KIND_DC;
    in_size_is_32   = 1'b0;
    foreach (above_seen[i]) begin
      above_seen[i] = 1'b0;
      left_seen[i]  = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: ramps on both edges, every predictor, row wrap, both TM clamps
    for (int i = 0; i < 16; i++)
      load_edge(POS_W'(i), PIX_W'(i * 17), PIX_W'(255 - i * 17),
                (i == 15) ? 8'd0 : PIX_W'(i * 16));
    gen_row(5'd0, KIND_DC, 1'b0);
    gen_row(5'd5, KIND_DC_LEFT, 1'b0);
    gen_row(5'd15, KIND_DC_TOP, 1'b0);
    gen_row(5'd31, KIND_DC_128, 1'b0);
    gen_row(5'd19, KIND_HOR, 1'b0);
    gen_row(5'd0, KIND_VER, 1'b0);
    gen_row(5'd0, KIND_TM, 1'b0);
    gen_row(5'd7, KIND_UNUSED, 1'b0);
    gen_row(5'd31, KIND_DC, 1'b1);
    load_edge(5'd15, 8'd255, 8'd0, 8'd255);
    gen_row(5'd15, KIND_TM, 1'b0);
    drain();

    // Back-pressure: receiver holds off while the sender keeps pushing rows
    rand_goal = 90;
    calm      = 1'b1;
    stall_req = 1'b1;
    repeat (12) gen_row(POS_W'($urandom_range(0, 31)), 3'($urandom_range(0, 7)), 1'b0);
    calm = 1'b0;
    drain();

    // Random: mostly complete blocks, some cut short, some noise
    pile_sums();
    while (n_items < rand_goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: load_block(1'($urandom_range(0, 1)), 1'b0);
        5, 6:          load_block(1'($urandom_range(0, 1)), 1'b1);
        7, 8: begin
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1))
              load_edge(POS_W'($urandom_range(0, 31)), rand_pixel(), rand_pixel(),
                        rand_pixel());
            else
              gen_row(POS_W'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)));
          end
        end
        default:       drain();
      endcase
    end

    // Final stretch with no idling on either side
    calm = 1'b1;
    load_block(1'b0, 1'b0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_count() != 0) begin
      $display("%0d expected words never arrived", sb.pending_count());
      sb.n_fail += sb.pending_count();
    end
    if (sb.n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
